### rtl/core/cifp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cifp_pkg
// Types and constants shared by the instruction flow predecoder modules.
// ----------------------------------------------------------------------------
package cifp_pkg;

    localparam int ADDR_BITS = 12;
    localparam int WORD_BITS = 10;
    localparam int SEL_BITS  = 4;

    // Flow kinds reported with every result item.
    localparam logic [2:0] FK_NONE     = 3'd0;
    localparam logic [2:0] FK_GOTO     = 3'd1;
    localparam logic [2:0] FK_KEYCODE  = 3'd2;
    localparam logic [2:0] FK_COMPUTED = 3'd3;
    localparam logic [2:0] FK_COND     = 3'd4;
    localparam logic [2:0] FK_CALL     = 3'd5;
    localparam logic [2:0] FK_RETURN   = 3'd6;
    localparam logic [2:0] FK_BANKSW   = 3'd7;

    // Instruction length codes.
    localparam logic [1:0] LEN_ONE = 2'd1;
    localparam logic [1:0] LEN_TWO = 2'd2;

    // State carried from one instruction to the next.
    typedef struct packed {
        logic                carry_clear_known;
        logic                select_pending;
        logic [SEL_BITS-1:0] select_high_bits;
    } t_flow_state;

    // One decoded result item.
    typedef struct packed {
        logic [ADDR_BITS-1:0] next_addr;
        logic [1:0]           insn_length;
        logic                 dest_bank;
        logic [ADDR_BITS-1:0] dest_addr;
        logic [2:0]           flow_kind;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/calc_insn_flow_predecoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calc_insn_flow_predecoder
// Control-flow predecoder for a 10-bit calculator instruction set.
// ----------------------------------------------------------------------------
//
// Channel  Direction  tdata fields (lowest bit first)
// s_axis   in         first_word[9:0], second_word[19:10], word_addr[31:20],
//                     bank[32], zero pad [39:33]
// m_axis   out        flow_kind[2:0], dest_addr[14:3], dest_bank[15],
//                     insn_length[17:16], next_addr[29:18], zero pad [31:30]
//
// Each item is captured in an input register, decoded by one level of
// shallow table logic and two 12-bit adds, and lands in the result register.
// One new item is accepted every cycle while the output side takes results.
// The flow state (carry known clear, pending delayed select) is updated as an
// item moves into the result register, which keeps items in strict order.
// Reset is synchronous and active low; it clears the valid flags and the flow
// state. A stall on the output holds both registers and drops s_axis_tready
// only once the input register is also occupied.
//
module calc_insn_flow_predecoder
    import cifp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // first_word, second_word, word_addr, bank, zero pad
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // flow_kind, dest_addr, dest_bank, insn_length, next_addr, zero pad
    output logic [31:0]      m_axis_tdata
);

    // Input stage.
    logic                 r_in_valid;
    logic [WORD_BITS-1:0] r_first_word;
    logic [WORD_BITS-1:0] r_second_word;
    logic [ADDR_BITS-1:0] r_word_addr;
    logic                 r_bank;

    // Result stage and flow state.
    logic                 r_out_valid;
    t_result              r_result;
    t_flow_state          r_state;

    t_result              w_res;
    t_flow_state          n_state;
    logic                 w_advance;
    logic                 w_accept;

    // The decoded item moves on when the result register is free or drains now.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    cifp_decode u_decode (
        .i_first_word  (r_first_word),
        .i_second_word (r_second_word),
        .i_word_addr   (r_word_addr),
        .i_bank        (r_bank),
        .i_state       (r_state),
        .o_result      (w_res),
        .o_state       (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first_word  <= s_axis_tdata[9:0];
            r_second_word <= s_axis_tdata[19:10];
            r_word_addr   <= s_axis_tdata[31:20];
            r_bank        <= s_axis_tdata[32];
        end
        if (w_advance) begin
            r_result <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_result};

`ifndef SYNTHESIS
    // Every result reports a length of one or two words.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.insn_length == LEN_ONE
                         || r_result.insn_length == LEN_TWO))
        else $error("insn_length out of range");

    // A pending select never lets an instruction pass as no flow.
    a_sel_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_state.select_pending) |-> (w_res.flow_kind != FK_NONE))
        else $error("pending select produced flow kind none");

    // A delayed select instruction leaves the select pending for the next item.
    a_sel_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_state.select_pending) |=> r_state.select_pending)
        else $error("delayed select was not recorded");

    // The input side is ready whenever its register is empty.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled while empty");
`endif

endmodule

`default_nettype wire

### rtl/core/cifp_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cifp_decode
// Combinational flow decode of one instruction and the next flow state.
// ----------------------------------------------------------------------------
module cifp_decode
    import cifp_pkg::*;
(
    input  wire logic [WORD_BITS-1:0] i_first_word,
    input  wire logic [WORD_BITS-1:0] i_second_word,
    input  wire logic [ADDR_BITS-1:0] i_word_addr,
    input  wire logic                 i_bank,
    input  wire t_flow_state          i_state,
    output t_result                   o_result,
    output t_flow_state               o_state
);

    // Misc subtable instruction codes (bits 5..2 of a class-zero word).
    localparam logic [3:0] MI_FLOW_A  = 4'd4;
    localparam logic [3:0] MI_COND_5  = 4'd5;
    localparam logic [3:0] MI_COND_7  = 4'd7;
    localparam logic [3:0] MI_GOTO    = 4'd8;
    localparam logic [3:0] MI_COND_9  = 4'd9;
    localparam logic [3:0] MI_COND_11 = 4'd11;
    localparam logic [3:0] MI_FLOW_B  = 4'd12;
    localparam logic [3:0] MI_DELSEL  = 4'd13;

    localparam logic [1:0] CL_MISC  = 2'd0;
    localparam logic [1:0] CL_CALL  = 2'd1;
    localparam logic [1:0] CL_ARITH = 2'd2;
    localparam logic [1:0] CL_BRNC  = 2'd3;

    logic [ADDR_BITS-1:0] w_addr1;
    logic [ADDR_BITS-1:0] w_addr2;
    logic [3:0]           w_inst;
    logic [3:0]           w_arg;
    logic [4:0]           w_op;
    logic                 w_sets_carry;
    logic                 w_is_test;
    logic                 w_two_word;
    logic [2:0]           w_flow;
    logic [ADDR_BITS-1:0] w_target;
    logic [2:0]           w_flow_one;
    logic [ADDR_BITS-1:0] w_target_one;

    assign w_addr1 = i_word_addr + ADDR_BITS'(1);
    assign w_addr2 = i_word_addr + ADDR_BITS'(2);
    assign w_inst  = i_first_word[5:2];
    assign w_arg   = i_first_word[9:6];
    assign w_op    = i_first_word[9:5];

    // Arithmetic ops that may change the carry, and the two-word tests.
    assign w_sets_carry = ((w_op >= 5'd9) && (w_op <= 5'd13)) || (w_op == 5'd15)
                       || ((w_op >= 5'd16) && (w_op <= 5'd21)) || (w_op == 5'd28);
    assign w_is_test    = (w_op >= 5'd22) && (w_op <= 5'd27);

    // Two-word forms: arithmetic tests, and misc codes 5, 7, 9 and 11.
    always_comb begin
        if (i_first_word[0]) begin
            w_two_word = 1'b0;
        end else if (i_first_word[1]) begin
            w_two_word = w_is_test;
        end else begin
            w_two_word = i_first_word[2] && (w_inst >= MI_COND_5) && (w_inst <= MI_COND_11);
        end
    end

    always_comb begin
        w_flow_one         = FK_NONE;
        w_target_one       = '0;
        o_state.carry_clear_known = 1'b1;
        o_state.select_pending    = 1'b0;
        o_state.select_high_bits  = '0;
        unique case (i_first_word[1:0])
            CL_MISC: begin
                unique case (w_inst)
                    MI_FLOW_A: begin
                        if (w_arg == 4'd0) begin
                            w_flow_one = FK_KEYCODE;
                        end else if (w_arg == 4'd2) begin
                            w_flow_one = FK_COMPUTED;
                        end else if (w_arg == 4'd8) begin
                            w_flow_one = FK_RETURN;
                        end
                    end
                    MI_FLOW_B: begin
                        if (w_arg == 4'd8) begin
                            w_flow_one = FK_BANKSW;
                        end else if (w_arg == 4'd12) begin
                            w_flow_one = FK_RETURN;
                        end
                    end
                    MI_COND_5, MI_COND_7, MI_COND_9, MI_COND_11: begin
                        w_flow_one = FK_COND;
                    end
                    MI_GOTO: begin
                        w_flow_one   = FK_GOTO;
                        w_target_one = {w_arg, w_addr1[7:0]};
                    end
                    MI_DELSEL: begin
                        o_state.select_pending   = 1'b1;
                        o_state.select_high_bits = w_arg;
                    end
                    default: begin
                    end
                endcase
            end
            CL_CALL: begin
                w_flow_one   = FK_CALL;
                w_target_one = {w_addr1[11:8], i_first_word[9:2]};
            end
            CL_ARITH: begin
                o_state.carry_clear_known = !w_sets_carry;
            end
            CL_BRNC: begin
                w_flow_one   = i_state.carry_clear_known ? FK_GOTO : FK_COND;
                w_target_one = {w_addr1[11:8], i_first_word[9:2]};
            end
            default: begin
            end
        endcase
    end

    // Two-word forms override the one-word decode.
    assign w_flow   = w_two_word ? FK_COND : w_flow_one;
    assign w_target = w_two_word ? {w_addr2[11:10], i_second_word} : w_target_one;

    // A pending delayed select forces the high target bits and turns no flow into a goto.
    always_comb begin
        o_result.flow_kind = w_flow;
        o_result.dest_addr = w_target;
        if (i_state.select_pending) begin
            if (w_flow == FK_NONE) begin
                o_result.flow_kind = FK_GOTO;
            end
            o_result.dest_addr = {i_state.select_high_bits, w_target[7:0]};
        end
        o_result.dest_bank   = i_bank;
        o_result.insn_length = w_two_word ? LEN_TWO : LEN_ONE;
        o_result.next_addr   = w_two_word ? w_addr2 : w_addr1;
    end

endmodule

`default_nettype wire
